FILE: hdl/tgd_pkg.sv
// Package for the tone generator: shared constants, operation codes and
// the sequencer state type. Used by tgd_div and tone_generator_with_duration_core.
// Depends on nothing else.
package tgd_pkg;

    localparam int COUNTER_BITS_DEF   = 16;
    localparam int PRESCALE_STEPS_DEF = 8;

    localparam logic [31:0] CORE_CLOCK_RESET = 32'd48000000;
    localparam int          MS_PER_S         = 1000;

    // Shared divider: 48-bit dividend covers duration * frequency.
    localparam int DIV_W     = 48;
    localparam int DIVISOR_W = 16;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_STOP  = 2'd2,
        OP_NONE  = 2'd3
    } tgd_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DIV_TOP,
        ST_MUL,
        ST_DIV_PER,
        ST_COMMIT
    } tgd_state_t;

endpackage

FILE: hdl/tgd_div.sv
// Restoring divider, one quotient bit per cycle, shared by the tone set-up.
// Depends on tgd_pkg for the dividend and divisor widths.
// A start pulse loads the operands; done pulses when the quotient is valid.
module tgd_div
    import tgd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_W-1:0]     dividend,
    input  logic [DIVISOR_W-1:0] divisor,
    output logic                 done,
    output logic [DIV_W-1:0]     quotient
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [CNT_W-1:0]     count_reg;
    logic [DIV_W-1:0]     quo_reg;
    logic [DIVISOR_W-1:0] rem_reg;
    logic [DIVISOR_W-1:0] div_reg;
    logic                 done_reg;

    logic [DIVISOR_W:0]   trial;
    logic                 fits;
    logic [DIVISOR_W:0]   diff;

    always_comb
    begin
        trial = {rem_reg, quo_reg[DIV_W-1]};
        fits  = (trial >= {1'b0, div_reg});
        diff  = trial - {1'b0, div_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            quo_reg   <= '0;
            rem_reg   <= '0;
            div_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                count_reg <= CNT_W'(DIV_W);
                quo_reg   <= dividend;
                rem_reg   <= '0;
                div_reg   <= divisor;
            end
            else if (count_reg != '0)
            begin
                // The remainder stays below the divisor, so it fits the narrow register.
                rem_reg   <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
                quo_reg   <= {quo_reg[DIV_W-2:0], fits};
                count_reg <= count_reg - CNT_W'(1);
                done_reg  <= (count_reg == CNT_W'(1));
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: hdl/tone_generator_with_duration_core.sv
// Square-wave tone generator with a prescaled timer and a duration count.
// Depends on tgd_pkg and on the shared divider tgd_div.
//
// Usage: each input transfer on s_* carries an operation in s_tuser and the
// frequency and duration in s_tdata. A tick stands for one core clock cycle
// and does not start the sequencer, so ticks may arrive back to back while
// the receiver keeps up; a stop, an unused operation or a start that works
// out as a stop are handled in the same way. A real start runs a sequencer
// around one shared restoring divider: a shift search over prescale shifts of
// 1 to PRESCALE_STEPS, a division (48 quotient bits, then the quotient handed
// over) for the counter top and, for a timed tone with a frequency, a product
// step and a second division for the period count, then a commit step that
// writes the result. The next item can be taken only after that result, and
// s_tready is low while the sequencer runs.
// Every input transfer yields exactly one result transfer on m_* holding the
// pin level, the playing flag and the finished pulse after that item.
// The result sits in an output register, so the next item is taken in the
// same cycle as the result leaves; if the receiver stalls, s_tready stays low
// until the result has been taken. The user must write the core clock register
// through cfg_we/cfg_wdata only while the block is idle; the block does not enforce
// this. After reset the timer is stopped, the core clock 48 MHz, no result pending.
module tone_generator_with_duration_core
    import tgd_pkg::*;
#(
    parameter int COUNTER_BITS   = COUNTER_BITS_DEF,
    parameter int PRESCALE_STEPS = PRESCALE_STEPS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,      // core_clock_hz
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,        // [15:0] frequency, [47:16] duration
    input  logic [1:0]  s_tuser,        // [1:0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata         // [0] pin_level, [1] playing, [2] finished, rest zero
);

    localparam int CB    = COUNTER_BITS;
    localparam int PS_W  = PRESCALE_STEPS;
    localparam int SH_W  = $clog2(PRESCALE_STEPS + 1);
    localparam int CMP_W = COUNTER_BITS + 32;

    localparam logic [CMP_W-1:0] SILENT_LIMIT =
        CMP_W'(MS_PER_S) * ((CMP_W'(1) << CB) - CMP_W'(1));
    localparam logic [DIV_W-1:0] MAX_TOP = (DIV_W'(1) << CB) - DIV_W'(1);

    tgd_state_t state_reg, state_next;

    logic [31:0]     core_clock_reg;
    logic [PS_W-1:0] prescale_count_reg, prescale_count_next;
    logic [SH_W-1:0] prescale_shift_reg, prescale_shift_next;
    logic [CB-1:0]   timer_count_reg, timer_count_next;
    logic [CB-1:0]   period_top_reg, period_top_next;
    logic [CB-1:0]   duty_compare_reg, duty_compare_next;
    logic [31:0]     periods_left_reg, periods_left_next;
    logic            running_reg, running_next;
    logic            timed_mode_reg, timed_mode_next;

    logic [15:0]     freq_reg, freq_next;
    logic [31:0]     dur_reg, dur_next;
    logic [31:0]     clk_reg, clk_next;
    logic [31:0]     periods_calc_reg, periods_calc_next;

    logic            out_valid_reg, out_valid_next;
    logic [2:0]      out_data_reg, out_data_next;

    logic            in_accept;
    tgd_op_t         op;
    logic [15:0]     in_freq;
    logic [31:0]     in_dur;
    logic            start_real;

    logic [31:0]     clk_shifted;
    logic [SH_W-1:0] shift_inc;
    logic [CMP_W-1:0] freq_limit;
    logic            search_hit;
    logic            search_end;

    logic            div_start;
    logic [DIV_W-1:0] div_dividend;
    logic [DIVISOR_W-1:0] div_divisor;
    logic            div_done;
    logic [DIV_W-1:0] div_quotient;

    logic [DIV_W-1:0] top_m1;
    logic [DIV_W-1:0] top_clamped;
    logic [PS_W-1:0] prescale_last;
    logic [DIV_W-1:0] product;
    logic            finished;

    assign op         = tgd_op_t'(s_tuser);
    assign in_freq    = s_tdata[15:0];
    assign in_dur     = s_tdata[47:16];
    assign s_tready   = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign in_accept  = s_tvalid && s_tready;
    assign start_real = (op == OP_START) && !((in_freq == '0) && (in_dur == '0));

    // Shift search: (clk >> s) / MAX < f is the same test as (clk >> s) < f * MAX.
    assign clk_shifted = clk_reg >> 1;
    assign shift_inc   = prescale_shift_reg + SH_W'(1);
    assign freq_limit  = (CMP_W'(freq_reg) << CB) - CMP_W'(freq_reg);
    assign search_hit  = (freq_reg == '0) ? (CMP_W'(clk_shifted) < SILENT_LIMIT)
                                          : (CMP_W'(clk_shifted) < freq_limit);
    assign search_end  = search_hit || (shift_inc == SH_W'(PRESCALE_STEPS));

    assign product = dur_reg * freq_reg;

    assign top_m1      = (div_quotient == '0) ? '0 : div_quotient - DIV_W'(1);
    assign top_clamped = (top_m1 > MAX_TOP)    ? MAX_TOP :
                         (top_m1 < DIV_W'(2))  ? DIV_W'(2) : top_m1;

    always_comb
    begin
        for (int i = 0; i < PS_W; i++)
        begin
            prescale_last[i] = (prescale_shift_reg > SH_W'(i));
        end
    end

    tgd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && start_real)
                begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (search_end)
                begin
                    state_next = ST_DIV_TOP;
                end
            end
            ST_DIV_TOP:
            begin
                if (div_done)
                begin
                    state_next = ((freq_reg == '0) || (dur_reg == '0)) ? ST_COMMIT : ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_DIV_PER;
            end
            ST_DIV_PER:
            begin
                if (div_done)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        prescale_count_next = prescale_count_reg;
        prescale_shift_next = prescale_shift_reg;
        timer_count_next    = timer_count_reg;
        period_top_next     = period_top_reg;
        duty_compare_next   = duty_compare_reg;
        periods_left_next   = periods_left_reg;
        running_next        = running_reg;
        timed_mode_next     = timed_mode_reg;
        freq_next           = freq_reg;
        dur_next            = dur_reg;
        clk_next            = clk_reg;
        periods_calc_next   = periods_calc_reg;
        div_start           = 1'b0;
        div_dividend        = DIV_W'(clk_shifted);
        div_divisor         = (freq_reg == '0) ? DIVISOR_W'(MS_PER_S) : freq_reg;
        finished            = 1'b0;
        out_valid_next      = out_valid_reg && !m_tready;
        out_data_next       = out_data_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (start_real)
                    begin
                        freq_next           = in_freq;
                        dur_next            = in_dur;
                        clk_next            = core_clock_reg;
                        prescale_shift_next = '0;
                    end
                    else
                    begin
                        case (op)
                            OP_TICK:
                            begin
                                if (running_reg)
                                begin
                                    if (prescale_count_reg < prescale_last)
                                    begin
                                        prescale_count_next = prescale_count_reg + PS_W'(1);
                                    end
                                    else
                                    begin
                                        prescale_count_next = '0;
                                        if (timer_count_reg < period_top_reg)
                                        begin
                                            timer_count_next = timer_count_reg + CB'(1);
                                        end
                                        else
                                        begin
                                            timer_count_next = '0;
                                            if (timed_mode_reg)
                                            begin
                                                if (periods_left_reg != '0)
                                                begin
                                                    periods_left_next = periods_left_reg - 32'd1;
                                                end
                                                // End of a timed tone, including a zero count.
                                                if (periods_left_reg <= 32'd1)
                                                begin
                                                    running_next    = 1'b0;
                                                    timed_mode_next = 1'b0;
                                                    finished        = 1'b1;
                                                end
                                            end
                                        end
                                    end
                                end
                            end
                            OP_START, OP_STOP:
                            begin
                                running_next        = 1'b0;
                                prescale_count_next = '0;
                                timer_count_next    = '0;
                                periods_left_next   = '0;
                                timed_mode_next     = 1'b0;
                            end
                            default:
                            begin
                            end
                        endcase
                        out_valid_next = 1'b1;
                        out_data_next  = {finished, (periods_left_next != '0),
                                          running_next && (timer_count_next < duty_compare_next)};
                    end
                end
            end
            ST_SEARCH:
            begin
                clk_next            = clk_shifted;
                prescale_shift_next = shift_inc;
                div_start           = search_end;
            end
            ST_DIV_TOP:
            begin
                if (div_done)
                begin
                    period_top_next   = top_clamped[CB-1:0];
                    duty_compare_next = (freq_reg == '0) ? '0 : top_clamped[CB:1];
                end
            end
            ST_MUL:
            begin
                div_start    = 1'b1;
                div_dividend = product;
                div_divisor  = DIVISOR_W'(MS_PER_S);
            end
            ST_DIV_PER:
            begin
                if (div_done)
                begin
                    periods_calc_next = (div_quotient[DIV_W-1:32] != '0) ? '1
                                                                         : div_quotient[31:0];
                end
            end
            ST_COMMIT:
            begin
                prescale_count_next = '0;
                timer_count_next    = '0;
                running_next        = 1'b1;
                timed_mode_next     = (dur_reg != '0);
                if (dur_reg == '0)
                begin
                    periods_left_next = 32'd1;
                end
                else if (freq_reg == '0)
                begin
                    periods_left_next = dur_reg;
                end
                else
                begin
                    periods_left_next = periods_calc_reg;
                end
                out_valid_next = 1'b1;
                out_data_next  = {1'b0, (periods_left_next != '0), (duty_compare_reg != '0)};
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            core_clock_reg     <= CORE_CLOCK_RESET;
            prescale_count_reg <= '0;
            prescale_shift_reg <= SH_W'(1);
            timer_count_reg    <= '0;
            period_top_reg     <= '0;
            duty_compare_reg   <= '0;
            periods_left_reg   <= '0;
            running_reg        <= 1'b0;
            timed_mode_reg     <= 1'b0;
            freq_reg           <= '0;
            dur_reg            <= '0;
            clk_reg            <= '0;
            periods_calc_reg   <= '0;
            out_valid_reg      <= 1'b0;
            out_data_reg       <= '0;
        end
        else
        begin
            state_reg          <= state_next;
            if (cfg_we)
            begin
                core_clock_reg <= cfg_wdata;
            end
            prescale_count_reg <= prescale_count_next;
            prescale_shift_reg <= prescale_shift_next;
            timer_count_reg    <= timer_count_next;
            period_top_reg     <= period_top_next;
            duty_compare_reg   <= duty_compare_next;
            periods_left_reg   <= periods_left_next;
            running_reg        <= running_next;
            timed_mode_reg     <= timed_mode_next;
            freq_reg           <= freq_next;
            dur_reg            <= dur_next;
            clk_reg            <= clk_next;
            periods_calc_reg   <= periods_calc_next;
            out_valid_reg      <= out_valid_next;
            out_data_reg       <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_data_reg};

    // A finished pulse always comes with the period count exhausted.
    a_finished_not_playing: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[2]) |-> !m_tdata[1])
        else $error("finished reported while periods remain");

    // While running, the counter top is at least two and the compare lies below it.
    a_top_range: assert property (@(posedge clk) disable iff (!rst_n)
        running_reg |-> ((period_top_reg >= CB'(2)) && (duty_compare_reg < period_top_reg)))
        else $error("counter top or compare out of range while running");

    // A restart may load a smaller top before the counter is cleared at commit.
    a_count_in_period: assert property (@(posedge clk) disable iff (!rst_n)
        (running_reg && (state_reg == ST_IDLE)) |-> (timer_count_reg <= period_top_reg))
        else $error("timer count beyond its top");

    // A real start occupies the sequencer, so the next cycle cannot take a transfer.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && start_real) |=> !s_tready)
        else $error("input taken while a start is being set up");

    a_no_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg != ST_IDLE) && (state_reg != ST_COMMIT)) |=> !$rose(m_tvalid))
        else $error("result produced before the start set-up completed");

endmodule

FILE: tb/sv/tgd_result_checker.sv
// Result checker for the tone generator: keeps its own copy of the timer,
// predicts pin, playing and finished for every input transfer and compares.
// Depends on tgd_pkg for the operation codes and the counter constants.
`timescale 1ns / 100ps

module tgd_result_checker
    import tgd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,        // [15:0] frequency, [47:16] duration
    input  logic [1:0]  s_tuser,        // [1:0] operation
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,        // [0] pin_level, [1] playing, [2] finished
    output int          fail_count,
    output int          pending,
    output int          items_in,
    output int          items_out,
    output int          tones_ended
);

    localparam logic [31:0] TOP_MAX = (32'd1 << COUNTER_BITS_DEF) - 32'd1;
    localparam logic [31:0] MS_DIV  = 32'(MS_PER_S);

    typedef struct packed {
        logic pin_level;
        logic playing;
        logic finished;
    } tone_result_t;

    tone_result_t owed_outputs[$];

    int fails   = 0;
    int n_in    = 0;
    int n_out   = 0;
    int n_ended = 0;

    // Shadow copy of the timer.
    logic [31:0] core_hz;
    logic [7:0]  pre_cnt;
    logic [3:0]  pre_shift;
    logic [15:0] tmr_cnt;
    logic [15:0] tmr_top;
    logic [15:0] duty_cmp;
    logic [31:0] left;
    logic        run;
    logic        timed;

    assign fail_count  = fails;
    assign pending     = owed_outputs.size();
    assign items_in    = n_in;
    assign items_out   = n_out;
    assign tones_ended = n_ended;

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("[%0t] result %0d: %s, wanted %0d, saw %0d", $realtime, n_out, what, want, got);
        fails++;
    endtask

    task automatic silence_timer();
        run     = 1'b0;
        pre_cnt = '0;
        tmr_cnt = '0;
        left    = '0;
        timed   = 1'b0;
    endtask

    task automatic load_tone(input logic [15:0] f, input logic [31:0] d);
        logic [31:0] c;
        logic [31:0] q;
        logic [63:0] prod;
        int          s;
        begin
            c = core_hz;
            pre_shift = 4'd1;
            for (s = 1; s <= PRESCALE_STEPS_DEF; s++)
            begin
                c = c >> 1;
                pre_shift = 4'(s);
                if (f == 16'd0)
                begin
                    if (c / MS_DIV < TOP_MAX)
                        break;
                end
                else if ({16'd0, f} > c / TOP_MAX)
                begin
                    break;
                end
            end
            q = (f == 16'd0) ? c / MS_DIV : c / {16'd0, f};
            if (q != 32'd0)
                q = q - 32'd1;
            if (q > TOP_MAX)
                q = TOP_MAX;
            if (q < 32'd2)
                q = 32'd2;
            tmr_top  = q[15:0];
            duty_cmp = (f != 16'd0) ? (q[15:0] >> 1) : 16'd0;
            pre_cnt  = '0;
            tmr_cnt  = '0;
            run      = 1'b1;
            if (d != 32'd0)
            begin
                timed = 1'b1;
                if (f == 16'd0)
                    left = d;
                else
                begin
                    prod = ({32'd0, d} * {48'd0, f}) / {32'd0, MS_DIV};
                    left = (prod > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
                end
            end
            else
            begin
                // An endless tone keeps a single period pending and never counts it down.
                timed = 1'b0;
                left  = 32'd1;
            end
        end
    endtask

    task automatic advance_one_tick(output logic done);
        logic [8:0] last;
        begin
            done = 1'b0;
            last = (9'd1 << pre_shift) - 9'd1;
            if (run)
            begin
                if ({1'b0, pre_cnt} < last)
                    pre_cnt = pre_cnt + 8'd1;
                else
                begin
                    pre_cnt = '0;
                    if (tmr_cnt < tmr_top)
                        tmr_cnt = tmr_cnt + 16'd1;
                    else
                    begin
                        tmr_cnt = '0;
                        if (timed)
                        begin
                            if (left != 32'd0)
                                left = left - 32'd1;
                            if (left == 32'd0)
                            begin
                                silence_timer();
                                done = 1'b1;
                            end
                        end
                    end
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        tone_result_t got;
        tone_result_t want;
        tone_result_t next;
        tgd_op_t      op;
        logic         done;
        if (!rst_n)
        begin
            core_hz   = CORE_CLOCK_RESET;
            pre_shift = 4'd1;
            tmr_top   = '0;
            duty_cmp  = '0;
            silence_timer();
            owed_outputs.delete();
        end
        else
        begin
            // Every output passes through the result register, so the output transfer is
            // matched before this edge's input is predicted.
            if (m_tvalid && m_tready)
            begin
                got = tone_result_t'({m_tdata[0], m_tdata[1], m_tdata[2]});
                if (owed_outputs.size() == 0)
                    report_mismatch("result with nothing owed", 0, int'(m_tdata));
                else
                begin
                    want = owed_outputs.pop_front();
                    if (got.pin_level !== want.pin_level)
                        report_mismatch("pin_level", want.pin_level, got.pin_level);
                    if (got.playing !== want.playing)
                        report_mismatch("playing", want.playing, got.playing);
                    if (got.finished !== want.finished)
                        report_mismatch("finished", want.finished, got.finished);
                end
                n_out++;
            end

            if (cfg_we)
                core_hz = cfg_wdata;

            if (s_tvalid && s_tready)
            begin
                op   = tgd_op_t'(s_tuser);
                done = 1'b0;
                case (op)
                    OP_TICK:
                        advance_one_tick(done);
                    OP_START:
                        if (s_tdata[15:0] == 16'd0 && s_tdata[47:16] == 32'd0)
                            silence_timer();
                        else
                            load_tone(s_tdata[15:0], s_tdata[47:16]);
                    OP_STOP:
                        silence_timer();
                    default:
                        ;
                endcase
                next.pin_level = run && (tmr_cnt < duty_cmp);
                next.playing   = (left != 32'd0);
                next.finished  = done;
                owed_outputs.push_back(next);
                if (done)
                    n_ended++;
                n_in++;
            end
        end
    end

endmodule

FILE: tb/sv/tb_tone_generator_with_duration_core.sv
// Top of the tone generator testbench: clock, reset, stimulus, receiver and verdict.
// Depends on tgd_pkg, tone_generator_with_duration_core and tgd_result_checker.
`timescale 1ns / 100ps

module tb_tone_generator_with_duration_core;
    import tgd_pkg::*;

    localparam int STALL_LIMIT  = 4000;
    localparam int HOLD_AT      = 700;
    localparam int HOLD_CYCLES  = 400;
    localparam int CALM_LO      = 250;
    localparam int CALM_HI      = 450;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 110;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [31:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata   = '0;        // [15:0] frequency, [47:16] duration
    logic [1:0]  s_tuser   = OP_TICK;   // [1:0] operation
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;               // [0] pin_level, [1] playing, [2] finished

    int fail_count;
    int pending;
    int items_in;
    int items_out;
    int tones_ended;
    int sent     = 0;
    int settings = 0;

    tone_generator_with_duration_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    tgd_result_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .pending     (pending),
        .items_in    (items_in),
        .items_out   (items_out),
        .tones_ended (tones_ended)
    );

    initial
    begin
        forever
            #5 clk = ~clk;
    end

    // Neither side inserts random idle cycles while this window of input transfers is being worked through.
    function automatic bit calm();
        return items_in >= CALM_LO && items_in < CALM_HI;
    endfunction

    initial
    begin : receiver
        int  hold_left;
        bit  held;
        hold_left = 0;
        held      = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held && items_in >= HOLD_AT)
            begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= calm() ? 1'b1 : ($urandom_range(0, 99) >= 26);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[%0t] no transfer for %0d cycles", $realtime, STALL_LIMIT);
        $display("tone_generator_with_duration_core verification failed");
        $finish;
    end

    // Entered and left at a falling edge; on return the item has been taken and
    // s_tvalid is still high, so the next call may keep it high without a dip.
    task automatic send(input tgd_op_t op, input logic [15:0] f, input logic [31:0] d);
        int n;
        begin
            while (!calm() && $urandom_range(0, 99) < 26)
            begin
                s_tvalid <= 1'b0;
                @(negedge clk);
            end
            s_tvalid <= 1'b1;
            s_tuser  <= op;
            s_tdata  <= {d, f};
            n = items_in;
            @(negedge clk);
            while (items_in == n)
                @(negedge clk);
            if (op != OP_NONE)
                sent++;
        end
    endtask

    task automatic send_tick();
        send(OP_TICK, 16'($urandom()), $urandom());
    endtask

    task automatic quiesce();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_core_clock(input logic [31:0] hz);
        quiesce();
        cfg_we    <= 1'b1;
        cfg_wdata <= hz;
        @(negedge clk);
        cfg_we    <= 1'b0;
        settings++;
    endtask

    function automatic logic [15:0] pick_freq();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25)
            return 16'd0;
        else if (r < 65)
            return 16'($urandom_range(1, 2000));
        else if (r < 85)
            return 16'($urandom_range(2000, 65535));
        return 16'($urandom());
    endfunction

    function automatic logic [31:0] pick_dur();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 32'd0;
        else if (r < 70)
            return 32'($urandom_range(1, 20));
        else if (r < 90)
            return 32'($urandom_range(1, 1000));
        return $urandom();
    endfunction

    // The budget is the number of items still owed to the current phase.
    task automatic run_sequence(input int budget);
        logic [15:0] f;
        logic [31:0] d;
        int          r;
        int          k;
        int          n;
        int          i;
        begin
            r = $urandom_range(0, 99);
            if (r < 72)
            begin
                f = pick_freq();
                d = pick_dur();
                send(OP_START, f, d);
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(80, 300) : $urandom_range(4, 40);
                if (n > budget - 1)
                    n = budget - 1;
                for (i = 0; i < n; i++)
                begin
                    k = $urandom_range(0, 99);
                    if (k == 0)
                        send(OP_STOP, 16'($urandom()), $urandom());
                    else if (k == 1)
                        send(OP_NONE, 16'($urandom()), $urandom());
                    else if (k == 2)
                        send(OP_START, f, d);
                    else
                        send_tick();
                end
            end
            else if (r < 90)
                send(tgd_op_t'($urandom_range(0, 3)), 16'($urandom()), $urandom());
            else
            begin
                // A tone that is overridden before it can play.
                send(OP_START, pick_freq(), pick_dur());
                if ($urandom_range(0, 1) == 0)
                    send(OP_STOP, 16'($urandom()), $urandom());
                else
                    send(OP_START, pick_freq(), pick_dur());
            end
        end
    endtask

    initial
    begin : stimulus
        int          p;
        int          mark;
        logic [31:0] hz;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed items at the reset core clock.
        send_tick();
        send(OP_NONE, 16'hFFFF, 32'hFFFF_FFFF);
        send(OP_STOP, 16'd0, 32'd0);
        send(OP_START, 16'd0, 32'd0);
        send(OP_START, 16'd1000, 32'd0);
        send_tick();
        send_tick();
        send(OP_NONE, 16'd0, 32'd0);
        send(OP_START, 16'hFFFF, 32'hFFFF_FFFF);
        send_tick();
        send(OP_START, 16'd1, 32'd1);
        send_tick();
        send(OP_START, 16'd0, 32'd5);
        send_tick();
        send(OP_STOP, 16'd0, 32'd0);

        // With no core clock the top clamps to its floor, and a timed tone that
        // works out to no periods plays one period before it ends.
        set_core_clock(32'd0);
        send(OP_START, 16'd1, 32'd1);
        repeat (7) send_tick();

        for (p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       hz = 32'd1000000;
                1:       hz = 32'hFFFF_FFFF;
                2:       hz = 32'd1;
                3:       hz = CORE_CLOCK_RESET;
                default: hz = (p % 3 == 0) ? $urandom() : 32'($urandom_range(0, 20000));
            endcase
            set_core_clock(hz);
            mark = sent;
            while (sent - mark < PHASE_ITEMS)
                run_sequence(PHASE_ITEMS - (sent - mark));
        end

        quiesce();
        $display("Run covered %0d input transfers and %0d results under %0d core clock settings;",
                 items_in, items_out, settings);
        $display("%0d timed tones ran to their end.", tones_ended);
        if (fail_count == 0)
            $display("tone_generator_with_duration_core verification clean");
        else
            $display("tone_generator_with_duration_core verification failed");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/tgd_pkg.sv
hdl/tgd_div.sv
hdl/tone_generator_with_duration_core.sv
tb/sv/tgd_result_checker.sv
tb/sv/tb_tone_generator_with_duration_core.sv
